FILE: sv/tbrs_pkg.sv
`default_nettype none

package tbrs_pkg;

	localparam logic [2:0] ACT_START_PER = 3'd0;
	localparam logic [2:0] ACT_START_ONE = 3'd1;
	localparam logic [2:0] ACT_STOP      = 3'd2;
	localparam logic [2:0] ACT_SUSPEND   = 3'd3;
	localparam logic [2:0] ACT_RESUME    = 3'd4;
	localparam logic [2:0] ACT_TICK      = 3'd5;

	localparam logic [31:0] FOREVER_COUNT = 32'hffff_ffff;
	localparam logic [31:0] ONE_SHOT_COUNT = 32'd1;

	// most expiries reported by one tick
	localparam int FIRE_LIMIT = 16;
	localparam int FCNT_W = $clog2(FIRE_LIMIT + 1);

	typedef enum logic [2:0] {
		OP_START_PER,
		OP_START_ONE,
		OP_STOP,
		OP_SUSPEND,
		OP_RESUME,
		OP_TICK
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_FLUSH
	} st_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  timer_index;
		logic [31:0] period_units;
		logic [15:0] handler_id;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  fired_slot;
		logic [15:0] fired_handler;
		logic        last_fired;
	} out_item_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  idx;
		logic [31:0] period;
		logic [15:0] handler;
		logic [31:0] now;
	} cmd_t;

	typedef struct packed {
		logic [31:0] base;
		logic [31:0] period;
		logic [15:0] handler;
		logic [31:0] remaining;
		logic [31:0] saved;
	} slot_rec_t;

	// units * 10, wrapping at 32 bits
	function automatic logic [31:0] period_scale(input logic [31:0] units);
		period_scale = (units << 3) + (units << 1);
	endfunction

endpackage

`default_nettype wire

FILE: sv/tbrs_ram.sv
`default_nettype none

module tbrs_ram #(
	parameter int WIDTH = 144,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  wr_en,
	input  wire logic [AW-1:0]         wr_addr,
	input  wire logic [WIDTH-1:0]      wr_data,
	input  wire logic                  rd_en,
	input  wire logic [AW-1:0]         rd_addr,
	output logic      [WIDTH-1:0]      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

FILE: sv/tbrs_front.sv
`default_nettype none

module tbrs_front #(
	parameter int TIMER_SLOTS = 16
) (
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire tbrs_pkg::in_item_t  in_item,
	input  wire logic                q_full,
	output logic                     push,
	output tbrs_pkg::cmd_t           push_cmd
);

	logic idx_ok;
	logic keep;

	assign idx_ok = {1'b0, in_item.timer_index} < 9'(TIMER_SLOTS);
	assign in_ready = !q_full;

	always_comb begin
		keep = 1'b0;
		push_cmd.op = tbrs_pkg::OP_TICK;
		push_cmd.idx = in_item.timer_index;
		push_cmd.period = tbrs_pkg::period_scale(in_item.period_units);
		push_cmd.handler = in_item.handler_id;
		push_cmd.now = in_item.now_ms;
		unique case (in_item.action)
			tbrs_pkg::ACT_START_PER: begin
				push_cmd.op = tbrs_pkg::OP_START_PER;
				keep = idx_ok;
			end
			tbrs_pkg::ACT_START_ONE: begin
				push_cmd.op = tbrs_pkg::OP_START_ONE;
				keep = idx_ok;
			end
			tbrs_pkg::ACT_STOP: begin
				push_cmd.op = tbrs_pkg::OP_STOP;
				keep = idx_ok;
			end
			tbrs_pkg::ACT_SUSPEND: begin
				push_cmd.op = tbrs_pkg::OP_SUSPEND;
				keep = idx_ok;
			end
			tbrs_pkg::ACT_RESUME: begin
				push_cmd.op = tbrs_pkg::OP_RESUME;
				keep = idx_ok;
			end
			tbrs_pkg::ACT_TICK: begin
				push_cmd.op = tbrs_pkg::OP_TICK;
				keep = 1'b1;
			end
			default: begin
				// unused codes are taken and dropped
				keep = 1'b0;
			end
		endcase
	end

	assign push = in_valid && in_ready && keep;

endmodule

`default_nettype wire

FILE: sv/tbrs_queue.sv
`default_nettype none

module tbrs_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire tbrs_pkg::cmd_t  push_cmd,
	output logic                 full,
	input  wire logic            pop,
	output logic                 empty,
	output tbrs_pkg::cmd_t       head
);

	// depth is a power of two so the pointers wrap on their own
	localparam int QDEPTH = 2;
	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	tbrs_pkg::cmd_t entry_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full = cnt_q == CNT_W'(QDEPTH);
	assign empty = cnt_q == '0;
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

FILE: sv/tbrs_back.sv
`default_nettype none

module tbrs_back #(
	parameter int TIMER_SLOTS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_valid,
	input  wire tbrs_pkg::cmd_t       q_cmd,
	output logic                      q_pop,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output tbrs_pkg::out_item_t       out_item
);

	localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
	localparam int REC_W = $bits(tbrs_pkg::slot_rec_t);
	localparam int FCNT_W = tbrs_pkg::FCNT_W;

	tbrs_pkg::st_t st_q, st_d;
	tbrs_pkg::cmd_t cmd_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic [IDX_W-1:0] ev_idx_q;
	logic ev_vld_q;
	logic [FCNT_W-1:0] fire_cnt_q;
	logic hold_vld_q;
	tbrs_pkg::out_item_t hold_q;
	logic out_vld_q;
	tbrs_pkg::out_item_t out_q;
	logic [TIMER_SLOTS-1:0] vld_q;
	logic rd_ok_q;

	logic rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	tbrs_pkg::slot_rec_t wr_rec;
	logic [REC_W-1:0] ram_rdata;

	tbrs_pkg::slot_rec_t rec;
	tbrs_pkg::slot_rec_t exec_rec;
	tbrs_pkg::slot_rec_t fire_rec;
	logic [31:0] due;
	logic fire;
	logic stall;
	logic limit_hit;
	logic more;
	logic out_free;
	logic out_push;
	tbrs_pkg::out_item_t out_d;
	logic scan_init;
	logic scan_adv;
	logic scan_rd;
	logic fire_take;
	logic hold_clr;

	tbrs_ram #(
		.WIDTH(REC_W),
		.DEPTH(TIMER_SLOTS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_rec),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (ram_rdata)
	);

	// slots never written read as idle
	assign rec = rd_ok_q ? tbrs_pkg::slot_rec_t'(ram_rdata) : '0;

	assign due = rec.base + rec.period;
	assign fire = ev_vld_q && (rec.remaining != '0) && (due <= cmd_q.now);
	assign out_free = !out_vld_q || out_ready;
	// a second expiry needs the held one moved out first
	assign stall = fire && hold_vld_q && !out_free;
	assign limit_hit = fire && (fire_cnt_q == FCNT_W'(tbrs_pkg::FIRE_LIMIT - 1));
	assign more = rd_idx_q != CNT_W'(TIMER_SLOTS);

	always_comb begin
		fire_rec = rec;
		fire_rec.base = cmd_q.now;
		if (rec.remaining != tbrs_pkg::FOREVER_COUNT) begin
			fire_rec.remaining = rec.remaining - 1'b1;
		end
	end

	always_comb begin
		exec_rec = rec;
		unique case (cmd_q.op)
			tbrs_pkg::OP_START_PER, tbrs_pkg::OP_START_ONE: begin
				exec_rec.base = cmd_q.now;
				exec_rec.period = cmd_q.period;
				exec_rec.handler = cmd_q.handler;
				exec_rec.remaining = (cmd_q.op == tbrs_pkg::OP_START_PER) ?
					tbrs_pkg::FOREVER_COUNT : tbrs_pkg::ONE_SHOT_COUNT;
			end
			tbrs_pkg::OP_STOP: begin
				exec_rec.handler = '0;
				exec_rec.remaining = '0;
			end
			tbrs_pkg::OP_SUSPEND: begin
				if (rec.remaining != '0) begin
					exec_rec.saved = rec.remaining;
					exec_rec.base = rec.base - cmd_q.now;
					exec_rec.remaining = '0;
				end
			end
			tbrs_pkg::OP_RESUME: begin
				if (rec.remaining == '0) begin
					exec_rec.remaining = rec.saved;
					exec_rec.base = rec.base + cmd_q.now;
					exec_rec.saved = '0;
				end
			end
			default: begin
				exec_rec = rec;
			end
		endcase
	end

	always_comb begin
		st_d = st_q;
		q_pop = 1'b0;
		rd_en = 1'b0;
		rd_addr = rd_idx_q[IDX_W-1:0];
		wr_en = 1'b0;
		wr_addr = ev_idx_q;
		wr_rec = fire_rec;
		out_push = 1'b0;
		out_d = hold_q;
		scan_init = 1'b0;
		scan_adv = 1'b0;
		scan_rd = 1'b0;
		fire_take = 1'b0;
		hold_clr = 1'b0;
		unique case (st_q)
			tbrs_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_cmd.op == tbrs_pkg::OP_TICK) begin
						scan_init = 1'b1;
						st_d = tbrs_pkg::ST_SCAN;
					end else begin
						rd_en = 1'b1;
						rd_addr = q_cmd.idx[IDX_W-1:0];
						st_d = tbrs_pkg::ST_EXEC;
					end
				end
			end
			tbrs_pkg::ST_EXEC: begin
				wr_en = 1'b1;
				wr_addr = cmd_q.idx[IDX_W-1:0];
				wr_rec = exec_rec;
				st_d = tbrs_pkg::ST_IDLE;
			end
			tbrs_pkg::ST_SCAN: begin
				// read of slot i+1 overlaps the check and write-back of slot i
				if (!stall) begin
					scan_adv = 1'b1;
					if (fire) begin
						wr_en = 1'b1;
						fire_take = 1'b1;
						if (hold_vld_q) begin
							out_push = 1'b1;
							out_d.last_fired = 1'b0;
						end
					end
					if (more && !limit_hit) begin
						rd_en = 1'b1;
						scan_rd = 1'b1;
					end
					if (limit_hit || !more) begin
						st_d = tbrs_pkg::ST_FLUSH;
					end
				end
			end
			tbrs_pkg::ST_FLUSH: begin
				if (!hold_vld_q) begin
					st_d = tbrs_pkg::ST_IDLE;
				end else if (out_free) begin
					out_push = 1'b1;
					out_d.last_fired = 1'b1;
					hold_clr = 1'b1;
					st_d = tbrs_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = tbrs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= tbrs_pkg::ST_IDLE;
			rd_idx_q <= '0;
			ev_vld_q <= 1'b0;
			fire_cnt_q <= '0;
			hold_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
			vld_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (scan_init) begin
				rd_idx_q <= '0;
			end else if (scan_rd) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (scan_init) begin
				ev_vld_q <= 1'b0;
			end else if (scan_adv) begin
				ev_vld_q <= scan_rd;
			end
			if (scan_init) begin
				fire_cnt_q <= '0;
			end else if (fire_take) begin
				fire_cnt_q <= fire_cnt_q + 1'b1;
			end
			if (scan_init || hold_clr) begin
				hold_vld_q <= 1'b0;
			end else if (fire_take) begin
				hold_vld_q <= 1'b1;
			end
			if (out_push) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_ok_q <= vld_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (scan_rd) begin
			ev_idx_q <= rd_idx_q[IDX_W-1:0];
		end
		if (fire_take) begin
			hold_q.fired_slot <= 8'(ev_idx_q);
			hold_q.fired_handler <= rec.handler;
			hold_q.last_fired <= 1'b0;
		end
		if (out_push) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_vld_q;
	assign out_item = out_q;

endmodule

`default_nettype wire

FILE: sv/timer_bank_repeat_suspend.sv
// Start, stop, suspend and resume: taken into a two-entry queue, then the slot sequencer
// reads, modifies and writes back one slot record (IDLE reads it, EXEC writes it back).
// Tick: pop, then one slot read per cycle while the output side does not stall, check of the
// last slot and flush; slot i is written back while slot i+1 is read.
// Each expiry is held back so the last of a tick can be flagged; at most 16 per tick.
// Reset clears the queue, sequencer and per-slot valid bits: every slot reads idle, no sweep.
`default_nettype none

module timer_bank_repeat_suspend #(
	parameter int TIMER_SLOTS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire tbrs_pkg::in_item_t   in_item,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output tbrs_pkg::out_item_t       out_item
);

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	tbrs_pkg::cmd_t q_in;
	tbrs_pkg::cmd_t q_head;

	tbrs_front #(
		.TIMER_SLOTS(TIMER_SLOTS)
	) u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_full   (q_full),
		.push     (q_push),
		.push_cmd (q_in)
	);

	tbrs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	tbrs_back #(
		.TIMER_SLOTS(TIMER_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (!q_empty),
		.q_cmd     (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

`ifndef SYNTHESIS
	a_fired_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, out_item.fired_slot} < 9'(TIMER_SLOTS)))
		else $error("fired slot out of range");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("command queue overflow");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command queue underflow");
`endif

endmodule

`default_nettype wire
